@@ hdl/ostab_pkg.sv @@
// Shared constants for the sorted order-statistic table: widths, command and status codes.
package ostab_pkg;

  localparam int CAPACITY_DEFAULT = 1024;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RANK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KTH    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRED   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

@@ hdl/order_statistic_sorted_table.sv @@
// Sorted multiset of signed values with insert, delete, rank, k-th, predecessor and successor.
// One command is taken at a time; the block is ready again the cycle after its result is loaded.
// Steps: a binary search, each step passing S_SRCH and S_SRCH_CMP; a fetch through S_FETCH
// and S_FETCH_CHK; and for insert and delete a shift of the moved entries in S_SHIFT, after
// which insert writes the new value in S_INS_WR.
// Synchronous reset empties the table by clearing the count; the value RAM is not cleared.
module order_statistic_sorted_table #(
  parameter int CAPACITY = ostab_pkg::CAPACITY_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ostab_pkg::VALUE_W-1:0]   s_axis_tdata,  // [31:0] operand
  input  logic [ostab_pkg::CMD_W-1:0]     s_axis_tuser,  // [2:0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ostab_pkg::VALUE_W-1:0]   m_axis_tdata,  // [31:0] answer
  output logic [ostab_pkg::STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);

  import ostab_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SRCH      = 4'd1;
  localparam logic [3:0] S_SRCH_CMP  = 4'd2;
  localparam logic [3:0] S_FETCH     = 4'd3;
  localparam logic [3:0] S_FETCH_CHK = 4'd4;
  localparam logic [3:0] S_SHIFT     = 4'd5;
  localparam logic [3:0] S_INS_WR    = 4'd6;
  localparam logic [3:0] S_DONE      = 4'd7;

  logic [3:0]          state;
  logic [CW-1:0]       count;
  logic [CMD_W-1:0]    cmd;
  logic [VALUE_W-1:0]  x;
  logic                strict;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       mid;
  logic [AW-1:0]       faddr;
  logic [CW-1:0]       src;
  logic [CW-1:0]       rem;
  logic [AW-1:0]       wdst;
  logic                pending;
  logic [VALUE_W-1:0]  answer;
  logic [STATUS_W-1:0] status;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid_w;
  logic                val_lt;
  logic                val_eq;
  logic                go_left;
  logic                accept;
  logic                out_free;
  logic                kth_ok;

  ostab_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_w   = mid_sum[CW:1];

  // The value comparisons, shared by the search steps and the delete match check.
  assign val_lt  = $signed(ram_rdata) < $signed(x);
  assign val_eq  = ram_rdata == x;
  assign go_left = strict ? (val_lt || val_eq) : val_lt;

  assign kth_ok = !s_axis_tdata[VALUE_W-1] && (s_axis_tdata != '0)
                  && (s_axis_tdata <= VALUE_W'(count));

  always_comb begin
    case (state)
      S_SRCH:  ram_raddr = mid_w[AW-1:0];
      S_FETCH: ram_raddr = faddr;
      S_SHIFT: ram_raddr = src[AW-1:0];
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wdst;
    ram_wdata = ram_rdata;
    case (state)
      S_SHIFT: begin
        ram_we = pending;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lo[AW-1:0];
        ram_wdata = x;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      pending       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd    <= s_axis_tuser;
            x      <= s_axis_tdata;
            answer <= '0;
            lo     <= '0;
            hi     <= count;
            strict <= (s_axis_tuser == CMD_INSERT) || (s_axis_tuser == CMD_SUCC);
            case (s_axis_tuser)
              CMD_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  status <= STATUS_FULL;
                  state  <= S_DONE;
                end else begin
                  status <= STATUS_OK;
                  state  <= S_SRCH;
                end
              end
              CMD_DELETE, CMD_RANK, CMD_PRED, CMD_SUCC: begin
                status <= STATUS_OK;
                state  <= S_SRCH;
              end
              CMD_KTH: begin
                if (kth_ok) begin
                  faddr  <= s_axis_tdata[AW-1:0] - AW'(1);
                  status <= STATUS_OK;
                  state  <= S_FETCH;
                end else begin
                  status <= STATUS_NONE;
                  state  <= S_DONE;
                end
              end
              default: begin
                status <= STATUS_NONE;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_w;
            state <= S_SRCH_CMP;
          end else begin
            // Search finished: lo is the boundary position.
            case (cmd)
              CMD_INSERT: begin
                src   <= count - CW'(1);
                rem   <= count - lo;
                state <= S_SHIFT;
              end
              CMD_RANK: begin
                answer <= VALUE_W'(lo) + VALUE_W'(1);
                state  <= S_DONE;
              end
              CMD_DELETE: begin
                if (lo < count) begin
                  faddr <= lo[AW-1:0];
                  state <= S_FETCH;
                end else begin
                  status <= STATUS_NONE;
                  state  <= S_DONE;
                end
              end
              CMD_PRED: begin
                if (lo == '0) begin
                  status <= STATUS_NONE;
                  state  <= S_DONE;
                end else begin
                  faddr <= AW'(lo - CW'(1));
                  state <= S_FETCH;
                end
              end
              CMD_SUCC: begin
                if (lo >= count) begin
                  status <= STATUS_NONE;
                  state  <= S_DONE;
                end else begin
                  faddr <= lo[AW-1:0];
                  state <= S_FETCH;
                end
              end
              default: begin
                status <= STATUS_NONE;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH_CMP: begin
          if (go_left) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_FETCH: begin
          state <= S_FETCH_CHK;
        end
        S_FETCH_CHK: begin
          if (cmd == CMD_DELETE) begin
            if (val_eq) begin
              src   <= lo + CW'(1);
              rem   <= count - lo - CW'(1);
              state <= S_SHIFT;
            end else begin
              status <= STATUS_NONE;
              state  <= S_DONE;
            end
          end else begin
            answer <= ram_rdata;
            state  <= S_DONE;
          end
        end
        S_SHIFT: begin
          // Reads run one entry ahead of writes; read and write addresses never coincide.
          if (rem != '0) begin
            pending <= 1'b1;
            rem     <= rem - CW'(1);
            if (cmd == CMD_INSERT) begin
              wdst <= AW'(src + CW'(1));
              src  <= src - CW'(1);
            end else begin
              wdst <= AW'(src - CW'(1));
              src  <= src + CW'(1);
            end
          end else begin
            pending <= 1'b0;
            if (!pending) begin
              if (cmd == CMD_INSERT) begin
                state <= S_INS_WR;
              end else begin
                count <= count - CW'(1);
                state <= S_DONE;
              end
            end
          end
        end
        S_INS_WR: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= answer;
            m_axis_tuser  <= status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/ostab_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module ostab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ verif/order_statistic_sorted_table_tb.sv @@
// Self-checking testbench for the sorted order-statistic table: directed and random commands.
module order_statistic_sorted_table_tb;
  import ostab_pkg::*;

  localparam int CAPACITY       = CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS   = 520;
  localparam int DRAIN_CYCLES   = 1100;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [VALUE_W-1:0]  answer;
    logic [STATUS_W-1:0] status;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] operand;
    logic               fixed;
    reply_t             reply;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [VALUE_W-1:0]  s_axis_tdata = '0;  // [31:0] operand
  logic [CMD_W-1:0]    s_axis_tuser = '0;  // [2:0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]  m_axis_tdata;       // [31:0] answer
  logic [STATUS_W-1:0] m_axis_tuser;       // [1:0] status

  int        stored_values[$];
  reply_t    pending_replies[$];
  stim_row_t directed_rows[$];

  int sender_idle_pct   = 11;
  int receiver_idle_pct = 59;
  int target_size       = 8;
  int mismatch_count    = 0;
  int quiet_cycles      = 0;

  order_statistic_sorted_table #(.CAPACITY(CAPACITY)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  function automatic int count_below(int x);
    int n;
    n = 0;
    foreach (stored_values[i]) if (stored_values[i] < x) n++;
    return n;
  endfunction

  function automatic int count_not_above(int x);
    int n;
    n = 0;
    foreach (stored_values[i]) if (stored_values[i] <= x) n++;
    return n;
  endfunction

  // Applies one command to the shadow multiset and returns the reply it must produce.
  function automatic reply_t compute_reply(logic [CMD_W-1:0] command,
                                           logic [VALUE_W-1:0] operand);
    int     x;
    int     pos;
    reply_t r;
    x = operand;
    r.answer = '0;
    r.status = STATUS_OK;
    case (command)
      CMD_INSERT: begin
        if (stored_values.size() >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          stored_values.insert(count_not_above(x), x);
        end
      end
      CMD_DELETE: begin
        pos = count_below(x);
        if (pos < stored_values.size() && stored_values[pos] == x) begin
          stored_values.delete(pos);
        end else begin
          r.status = STATUS_NONE;
        end
      end
      CMD_RANK: begin
        r.answer = count_below(x) + 1;
      end
      CMD_KTH: begin
        if (x < 1 || x > stored_values.size()) begin
          r.status = STATUS_NONE;
        end else begin
          r.answer = stored_values[x-1];
        end
      end
      CMD_PRED: begin
        pos = count_below(x);
        if (pos == 0) begin
          r.status = STATUS_NONE;
        end else begin
          r.answer = stored_values[pos-1];
        end
      end
      CMD_SUCC: begin
        pos = count_not_above(x);
        if (pos >= stored_values.size()) begin
          r.status = STATUS_NONE;
        end else begin
          r.answer = stored_values[pos];
        end
      end
      default: begin
        r.status = STATUS_NONE;
      end
    endcase
    return r;
  endfunction

  // Mostly values near zero or already stored, so deletes hit and bounds land on neighbors.
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    int n;
    sel = $urandom_range(99);
    n = stored_values.size();
    if (sel < 30) return $urandom_range(40) - 20;
    if (sel < 55 && n != 0) return stored_values[$urandom_range(n-1)];
    if (sel < 65 && n != 0) return stored_values[$urandom_range(n-1)] + $urandom_range(2) - 1;
    if (sel < 75) begin
      case ($urandom_range(3))
        0: return VALUE_MIN;
        1: return VALUE_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] command, input logic [VALUE_W-1:0] operand,
                         input logic fixed, input logic [VALUE_W-1:0] answer,
                         input logic [STATUS_W-1:0] status);
    stim_row_t row;
    row.command = command;
    row.operand = operand;
    row.fixed = fixed;
    row.reply.answer = answer;
    row.reply.status = status;
    directed_rows = {directed_rows, row};
  endtask

  // Drives one command and records its expected reply at the edge of the transfer.
  task automatic issue(input logic [CMD_W-1:0] command, input logic [VALUE_W-1:0] operand,
                       input logic fixed, input logic [VALUE_W-1:0] answer,
                       input logic [STATUS_W-1:0] status);
    reply_t predicted;
    reply_t typed;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= operand;
    s_axis_tuser <= command;
    do @(posedge clk); while (!s_axis_tready);
    predicted = compute_reply(command, operand);
    typed.answer = answer;
    typed.status = status;
    pending_replies = {pending_replies, (fixed ? typed : predicted)};
  endtask

  task automatic issue_checked(input logic [CMD_W-1:0] command,
                               input logic [VALUE_W-1:0] operand);
    issue(command, operand, 1'b0, '0, STATUS_OK);
  endtask

  task automatic issue_random();
    int               sel;
    logic             grow;
    logic [CMD_W-1:0] command;
    sel = $urandom_range(99);
    grow = stored_values.size() < target_size;
    if (sel < 3) command = (sel == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    else if (sel < 33) command = grow ? CMD_INSERT : CMD_DELETE;
    else if (sel < 45) command = grow ? CMD_DELETE : CMD_INSERT;
    else if (sel < 59) command = CMD_RANK;
    else if (sel < 73) command = CMD_KTH;
    else if (sel < 86) command = CMD_PRED;
    else command = CMD_SUCC;
    if (command == CMD_KTH && $urandom_range(9) < 8) begin
      issue_checked(command, $urandom_range(stored_values.size() + 1));
    end else begin
      issue_checked(command, pick_value());
    end
  endtask

  // Holds the sender off until every reply in flight has been checked.
  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: answer %0d, status %0d", $signed(m_axis_tdata), m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata !== want.answer) begin
          $error("answer mismatch: expected %0d, actual %0d",
                 $signed(want.answer), $signed(m_axis_tdata));
          mismatch_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Empty table first, then duplicates and the extremes of the operand range.
    add_row(CMD_RANK,    32'd0,     1'b1, 32'd1, STATUS_OK);
    add_row(CMD_KTH,     32'd1,     1'b1, '0,    STATUS_NONE);
    add_row(CMD_PRED,    32'd0,     1'b1, '0,    STATUS_NONE);
    add_row(CMD_SUCC,    32'd0,     1'b1, '0,    STATUS_NONE);
    add_row(CMD_DELETE,  32'd5,     1'b1, '0,    STATUS_NONE);
    add_row(CMD_SPARE_6, 32'd0,     1'b1, '0,    STATUS_NONE);
    add_row(CMD_SPARE_7, '1,        1'b1, '0,    STATUS_NONE);
    add_row(CMD_INSERT,  VALUE_MAX, 1'b1, '0,    STATUS_OK);
    add_row(CMD_INSERT,  VALUE_MIN, 1'b1, '0,    STATUS_OK);
    add_row(CMD_INSERT,  32'd0,     1'b1, '0,    STATUS_OK);
    add_row(CMD_INSERT,  32'd0,     1'b1, '0,    STATUS_OK);
    add_row(CMD_INSERT,  -32'sd5,   1'b1, '0,    STATUS_OK);
    add_row(CMD_RANK,    32'd0,     1'b0, '0,    STATUS_OK);
    add_row(CMD_RANK,    VALUE_MAX, 1'b0, '0,    STATUS_OK);
    add_row(CMD_KTH,     32'd0,     1'b1, '0,    STATUS_NONE);
    add_row(CMD_KTH,     '1,        1'b1, '0,    STATUS_NONE);
    add_row(CMD_KTH,     32'd5,     1'b0, '0,    STATUS_OK);
    add_row(CMD_KTH,     32'd6,     1'b1, '0,    STATUS_NONE);
    add_row(CMD_KTH,     VALUE_MIN, 1'b1, '0,    STATUS_NONE);
    add_row(CMD_PRED,    VALUE_MIN, 1'b1, '0,    STATUS_NONE);
    add_row(CMD_SUCC,    VALUE_MAX, 1'b1, '0,    STATUS_NONE);
    add_row(CMD_PRED,    32'd0,     1'b0, '0,    STATUS_OK);
    add_row(CMD_SUCC,    32'd0,     1'b0, '0,    STATUS_OK);
    add_row(CMD_DELETE,  32'd0,     1'b1, '0,    STATUS_OK);
    add_row(CMD_DELETE,  32'd1,     1'b1, '0,    STATUS_NONE);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].command, directed_rows[i].operand, directed_rows[i].fixed,
            directed_rows[i].reply.answer, directed_rows[i].reply.status);
    end
    wait_for_replies();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        sender_idle_pct = 59;
        receiver_idle_pct = 11;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (n % 100 == 0) target_size = ($urandom_range(9) == 0) ? 150 : $urandom_range(48);
      issue_random();
    end
    wait_for_replies();

    // Empty the table from the top down.
    while (stored_values.size() != 0) begin
      issue_checked(CMD_DELETE, stored_values[stored_values.size()-1]);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
